// File: sv/tphcs_pkg.sv
package tphcs_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned CandW = DataW + 2;
  localparam logic [DataW-1:0] HoldTicks = 16'd10;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTorqueUpper  = 3'd0,
    CfgTorqueLower  = 3'd1,
    CfgPitchStart   = 3'd2,
    CfgPitchFloor   = 3'd3,
    CfgSpeedUpper   = 3'd4,
    CfgSpeedLower   = 3'd5,
    CfgTorqueIncr   = 3'd6,
    CfgPitchDecr    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DataW-1:0]        torque_upper;
    logic [DataW-1:0]        torque_lower;
    logic signed [DataW-1:0] pitch_start;
    logic signed [DataW-1:0] pitch_floor;
    logic [DataW-1:0]        speed_upper;
    logic [DataW-1:0]        speed_lower;
    logic [DataW-1:0]        torque_increment;
    logic [DataW-1:0]        pitch_decrement;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0]        torque_now;
    logic signed [DataW-1:0] pitch_now;
    logic                    direction_down;
    logic [DataW-1:0]        hold_count;
  } seq_state_t;

endpackage

// File: sv/tphcs_step.sv
module tphcs_step import tphcs_pkg::*; (
  input  cfg_t             cfg_i,
  input  seq_state_t       state_i,
  input  logic [DataW-1:0] speed_i,
  input  logic             restart_i,
  output seq_state_t       state_o
);

  logic [DataW-1:0]        hold_inc;
  logic                    fire;
  logic signed [CandW-1:0] cand;
  logic signed [CandW-1:0] new_pitch;
  logic                    speed_ok;
  logic                    keep;

  always_comb begin
    hold_inc = state_i.hold_count + 16'd1;
    fire     = hold_inc > HoldTicks;

    if (state_i.direction_down) begin
      cand     = $signed({2'b00, state_i.torque_now}) - $signed({2'b00, cfg_i.torque_increment});
      speed_ok = speed_i < cfg_i.speed_upper;
    end else begin
      cand     = $signed({2'b00, state_i.torque_now}) + $signed({2'b00, cfg_i.torque_increment});
      speed_ok = speed_i > cfg_i.speed_lower;
    end

    keep = (cand < $signed({2'b00, cfg_i.torque_upper}))
        && (cand > $signed({2'b00, cfg_i.torque_lower}))
        && speed_ok;

    new_pitch = CandW'(state_i.pitch_now) - $signed({2'b00, cfg_i.pitch_decrement});

    state_o = state_i;
    if (restart_i) begin
      state_o.torque_now     = cfg_i.torque_lower;
      state_o.pitch_now      = cfg_i.pitch_start;
      state_o.direction_down = 1'b0;
      state_o.hold_count     = '0;
    end else if (!fire) begin
      state_o.hold_count = hold_inc;
    end else begin
      state_o.hold_count = '0;
      if (keep) begin
        state_o.torque_now = cand[DataW-1:0];
      end else begin
        state_o.direction_down = !state_i.direction_down;
        if (new_pitch > CandW'(cfg_i.pitch_floor)) begin
          state_o.pitch_now = new_pitch[DataW-1:0];
        end
      end
    end
  end

endmodule

// File: sv/torque_pitch_hill_climb_sequencer_unit.sv
// channel   | direction | transfer on            | payload
// ----------+-----------+------------------------+-------------------------------------
// s_axis    | in        | s_axis_tvalid & tready | tdata speed, tuser restart
// m_axis    | out       | m_axis_tvalid & tready | tdata torque, pitch, stepping_down
// cfg       | in        | cfg_we_i               | register index, 16-bit value
//
// one tick per cycle sustained while m_axis is not stalled; stages: input register, result register
// sequencer state updates as an item moves from the input register to the result register
// reset clears the state to zero torque, zero pitch, stepping up, counter zero
// a stalled result register holds the input register; an empty input register can still take one item
module torque_pitch_hill_climb_sequencer_unit import tphcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DataW-1:0]    s_axis_tdata,   // [15:0] generator_speed
  input  logic                s_axis_tuser,   // [0] restart
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [15:0] torque_demand, [31:16] pitch_demand,
                                              // [32] stepping_down, [39:33] zero
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [DataW-1:0]    cfg_wdata_i
);

  cfg_t             cfg_q;
  seq_state_t       state_q, state_d;
  logic             in_valid_q;
  logic [DataW-1:0] in_speed_q;
  logic             in_restart_q;
  logic             out_valid_q;
  logic             out_free;
  logic             advance;
  cfg_idx_e         cfg_idx;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign cfg_idx       = cfg_idx_e'(cfg_addr_i);

  tphcs_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .speed_i   (in_speed_q),
    .restart_i (in_restart_q),
    .state_o   (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.torque_upper     <= 16'hFFFF;
      cfg_q.torque_lower     <= '0;
      cfg_q.pitch_start      <= '0;
      cfg_q.pitch_floor      <= '0;
      cfg_q.speed_upper      <= 16'hFFFF;
      cfg_q.speed_lower      <= '0;
      cfg_q.torque_increment <= '0;
      cfg_q.pitch_decrement  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CfgTorqueUpper: cfg_q.torque_upper     <= cfg_wdata_i;
        CfgTorqueLower: cfg_q.torque_lower     <= cfg_wdata_i;
        CfgPitchStart:  cfg_q.pitch_start      <= cfg_wdata_i;
        CfgPitchFloor:  cfg_q.pitch_floor      <= cfg_wdata_i;
        CfgSpeedUpper:  cfg_q.speed_upper      <= cfg_wdata_i;
        CfgSpeedLower:  cfg_q.speed_lower      <= cfg_wdata_i;
        CfgTorqueIncr:  cfg_q.torque_increment <= cfg_wdata_i;
        CfgPitchDecr:   cfg_q.pitch_decrement  <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_speed_q   <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, state_q.direction_down, state_q.pitch_now, state_q.torque_now};

endmodule
